>>> rtl/core/assert_macros.svh
// Assertion macros for the pixel unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JESC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define JESC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define JESC_ASSERT_IMP(label, clk, rst, ante, cons)
`define JESC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/jesc_pkg.sv
// Types, constants and helper functions of the Julia escape-time pixel unit.
package jesc_pkg;

   localparam int DIM_W       = 13;
   localparam int LIMIT_W     = 10;
   localparam int RATIO_W     = 24;
   localparam int COORD_W     = 12;
   localparam int MAG_W       = 13;
   localparam int COUNT_W     = 11;
   localparam int DIV_NUM_W   = 58;
   localparam int DIV_DEN_W   = 28;
   localparam int DIV_CNT_W   = 6;
   localparam int MAX_DIMENSION = 4096;
   localparam int CSR_ADDR_W  = 5;

   localparam logic [2:0] REG_C_REAL   = 3'd0;
   localparam logic [2:0] REG_C_IMAG   = 3'd1;
   localparam logic [2:0] REG_LIMIT    = 3'd2;
   localparam logic [2:0] REG_WIDTH    = 3'd3;
   localparam logic [2:0] REG_HEIGHT   = 3'd4;
   localparam logic [2:0] REG_RATIO    = 3'd5;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] escape_value;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
      else r = d;
      return r;
   endfunction

   // sign * quotient, saturated to 32-bit signed
   function automatic logic [31:0] sat_quot(input logic neg, input logic [DIV_NUM_W-1:0] q);
      logic [31:0] r;
      if (neg) begin
         if (q > DIV_NUM_W'(64'h8000_0000)) r = 32'h8000_0000;
         else r = 32'd0 - q[31:0];
      end else begin
         if (q > DIV_NUM_W'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
         else r = q[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [37:0] v);
      logic [31:0] r;
      if (v > 38'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -38'sh0_8000_0000) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

>>> rtl/core/jesc_mul.sv
// Shared registered 32 x 32 signed multiplier.
module jesc_mul (
   input  logic               clock,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic signed [63:0] prod
);
   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;
endmodule

>>> rtl/core/jesc_div.sv
// Restoring divider, one quotient bit per cycle.
module jesc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  jesc_pkg::div_req_type req,
   output jesc_pkg::div_rsp_type rsp
);
   import jesc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, q_ff[DIV_NUM_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = req.num;
         den_in  = req.den;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            q_in   = {q_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;
endmodule

>>> rtl/core/julia_escape_time_pixel_unit.sv
// Julia escape-time pixel unit: coordinate mapping, z*z+c iteration, scaling and colour.
// Sequence: one multiply and two divides map the coordinate, then each iteration steps
//   through S_IT_RR, S_IT_II, S_IT_CHK and S_IT_UPD (shared multiplier, three products an
//   iteration), then the scaling divide (skipped unless count < limit) and the result.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous, active high; configuration registers return to their defaults,
//   the sequencer goes idle and no result is pending.
module julia_escape_time_pixel_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  jesc_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output jesc_pkg::rsp_type            rsp_payload,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [jesc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   `include "assert_macros.svh"
   import jesc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MAP_MUL, S_DIVX_GO, S_DIVX_WAIT, S_DIVY_GO, S_DIVY_WAIT,
      S_IT_RR, S_IT_II, S_IT_CHK, S_IT_UPD, S_SCALE, S_SCALE_WAIT, S_FINISH
   } state_type;

   // ---- configuration registers
   logic [31:0]        c_real_ff, c_imag_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff <= '0;
         c_imag_ff <= '0;
         limit_ff  <= LIMIT_W'(255);
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         ratio_ff  <= RATIO_W'(65536);
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_C_REAL: c_real_ff <= csr_pwdata;
            REG_C_IMAG: c_imag_ff <= csr_pwdata;
            REG_LIMIT:  limit_ff  <= csr_pwdata[LIMIT_W-1:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[DIM_W-1:0];
            REG_RATIO:  ratio_ff  <= csr_pwdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_C_REAL: csr_prdata = c_real_ff;
         REG_C_IMAG: csr_prdata = c_imag_ff;
         REG_LIMIT:  csr_prdata = {22'd0, limit_ff};
         REG_WIDTH:  csr_prdata = {19'd0, width_ff};
         REG_HEIGHT: csr_prdata = {19'd0, height_ff};
         REG_RATIO:  csr_prdata = {8'd0, ratio_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // ---- item state
   state_type          state_ff, state_in;
   logic               neg_x_ff, neg_y_ff;
   logic [MAG_W-1:0]   mx_ff, my_ff;
   logic [DIM_W-1:0]   w_ff, h_ff;
   logic [RATIO_W-1:0] r_ff;
   logic               r_ge_ff;
   logic [DIV_DEN_W-1:0] hr_ff;
   logic [31:0]        zr_ff, zi_ff;
   logic [63:0]        rr_ff, ii_ff;
   logic [COUNT_W-1:0] n_ff;
   logic [7:0]         val_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // accept-time mapping inputs
   logic [DIM_W-1:0]   w_cl, h_cl;
   logic [RATIO_W-1:0] r_cl;
   logic signed [14:0] dx, dy;
   logic               accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign w_cl      = dim_clamp(width_ff);
   assign h_cl      = dim_clamp(height_ff);
   assign r_cl      = (ratio_ff == '0) ? RATIO_W'(1) : ratio_ff;
   assign dx = $signed({2'b0, req_payload.pixel_x, 1'b0}) - $signed({2'b0, w_cl});
   assign dy = $signed({2'b0, req_payload.pixel_y, 1'b0}) - $signed({2'b0, h_cl});

   // ---- shared multiplier
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;

   always_comb begin
      case (state_ff)
         S_MAP_MUL: begin
            mul_a = r_ge_ff ? $signed({19'd0, mx_ff}) : $signed({19'd0, h_ff});
            mul_b = $signed({8'd0, r_ff});
         end
         S_IT_RR:  begin mul_a = zr_ff; mul_b = zr_ff; end
         S_IT_II:  begin mul_a = zi_ff; mul_b = zi_ff; end
         S_IT_CHK: begin mul_a = zr_ff; mul_b = zi_ff; end
         default:  begin mul_a = '0;    mul_b = '0;    end
      endcase
   end

   jesc_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod(prod));

   // ---- shared divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         S_DIVX_GO: begin
            div_req.start = 1'b1;
            div_req.num   = r_ge_ff ? DIV_NUM_W'({prod[36:0], 13'd0})
                                    : DIV_NUM_W'({mx_ff, 29'd0});
            div_req.den   = DIV_DEN_W'(w_ff);
         end
         S_DIVY_GO: begin
            div_req.start = 1'b1;
            div_req.num   = r_ge_ff ? DIV_NUM_W'({my_ff, 29'd0}) : {my_ff, 45'd0};
            div_req.den   = r_ge_ff ? DIV_DEN_W'(h_ff) : hr_ff;
         end
         S_SCALE: begin
            div_req.start = (n_ff < {1'b0, limit_ff});
            div_req.num   = DIV_NUM_W'({n_ff, 8'd0}) - DIV_NUM_W'(n_ff);
            div_req.den   = DIV_DEN_W'(limit_ff);
         end
         default: ;
      endcase
   end

   jesc_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // ---- iteration datapath
   logic [63:0]        mag_sum;
   logic               escape;
   logic signed [64:0] diff;
   logic signed [37:0] nr_wide, ni_wide;

   assign mag_sum = rr_ff + prod;                       // rr + ii, both non-negative
   assign escape  = (mag_sum >= 64'h0400_0000_0000_0000) || (n_ff > {1'b0, limit_ff});
   assign diff    = $signed({1'b0, rr_ff}) - $signed({1'b0, ii_ff});
   // floor shifts: arithmetic right shift rounds toward minus infinity
   assign nr_wide = $signed({diff[64], diff[64:28]}) + $signed({{6{c_real_ff[31]}}, c_real_ff});
   assign ni_wide = $signed({prod[63], prod[63:27]}) + $signed({{6{c_imag_ff[31]}}, c_imag_ff});

   logic out_free;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   logic div_waiting;
   assign div_waiting = (state_ff == S_DIVX_WAIT) || (state_ff == S_DIVY_WAIT) ||
                        (state_ff == S_SCALE_WAIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (accept) state_in = S_MAP_MUL;
         S_MAP_MUL:    state_in = S_DIVX_GO;
         S_DIVX_GO:    state_in = S_DIVX_WAIT;
         S_DIVX_WAIT:  if (div_rsp.done) state_in = S_DIVY_GO;
         S_DIVY_GO:    state_in = S_DIVY_WAIT;
         S_DIVY_WAIT:  if (div_rsp.done) state_in = S_IT_RR;
         S_IT_RR:      state_in = S_IT_II;
         S_IT_II:      state_in = S_IT_CHK;
         S_IT_CHK:     state_in = escape ? S_SCALE : S_IT_UPD;
         S_IT_UPD:     state_in = S_IT_RR;
         S_SCALE:      state_in = div_req.start ? S_SCALE_WAIT : S_FINISH;
         S_SCALE_WAIT: if (div_rsp.done) state_in = S_FINISH;
         S_FINISH:     if (out_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FINISH && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: if (accept) begin
            neg_x_ff <= dx[14];
            neg_y_ff <= dy[14];
            mx_ff    <= dx[14] ? MAG_W'(-dx) : MAG_W'(dx);
            my_ff    <= dy[14] ? MAG_W'(-dy) : MAG_W'(dy);
            w_ff     <= w_cl;
            h_ff     <= h_cl;
            r_ff     <= r_cl;
            r_ge_ff  <= (r_cl[23:16] != 8'd0);
         end
         S_DIVX_GO:   hr_ff <= prod[DIV_DEN_W-1:0];
         S_DIVX_WAIT: if (div_rsp.done) zr_ff <= sat_quot(neg_x_ff, div_rsp.quot);
         S_DIVY_WAIT: if (div_rsp.done) begin
            zi_ff <= sat_quot(neg_y_ff, div_rsp.quot);
            n_ff  <= COUNT_W'(1);
         end
         S_IT_II:  rr_ff <= prod;
         S_IT_CHK: ii_ff <= prod;
         S_IT_UPD: begin
            zr_ff <= sat32(nr_wide);
            zi_ff <= sat32(ni_wide);
            n_ff  <= n_ff + 1'b1;
         end
         S_SCALE:      val_ff <= '0;
         S_SCALE_WAIT: if (div_rsp.done) val_ff <= div_rsp.quot[7:0];
         S_FINISH: if (out_free) begin
            rsp_ff.escape_value <= val_ff;
            rsp_ff.red          <= (val_ff == '0) ? 8'd0 : 8'd255;
            rsp_ff.green        <= (val_ff == '0) ? 8'd0 : 8'd255 - val_ff;
            rsp_ff.blue         <= (val_ff == '0) ? 8'd0 : 8'd255 - val_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `JESC_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, req_stall)
   `JESC_ASSERT_IMP(a_div_done_waiting, clock, reset, div_rsp.done, div_waiting)
   `JESC_ASSERT_IMP(a_update_in_limit, clock, reset, state_ff == S_IT_UPD, n_ff <= {1'b0, limit_ff})
endmodule

>>> tb/julia_escape_time_pixel_unit_tb.sv
// Self-checking testbench for the Julia escape-time pixel unit.
`timescale 1ns / 100ps

module julia_escape_time_pixel_unit_tb;
   import jesc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 20_000_000;
   localparam int DRAIN_CYCLES = 60;          // settle time before a register write
   localparam int HOLD_CYCLES  = 6000;        // long receiver hold-off, > one item
   localparam logic [2:0] REG_UNUSED = 3'd6;  // beyond the register map: ignored

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   julia_escape_time_pixel_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the register file, kept in step with every CSR write
   logic [31:0] shadow_c_real, shadow_c_imag;
   logic [9:0]  shadow_limit;
   logic [12:0] shadow_width, shadow_height;
   logic [23:0] shadow_ratio;

   rsp_type expected_pixels[$];
   int unsigned cycle_count = 0;
   int mismatch_count = 0;
   int pixels_checked = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_go = 1'b0;
   logic hold_on = 1'b0;

   // ---- escape-time predictor ----

   function automatic longint clamp_q28(input bit neg, input longint unsigned num,
                                        input longint unsigned den);
      longint unsigned q;
      q = num / den;
      if (neg) begin
         if (q > 64'd2147483648) q = 64'd2147483648;
         return -longint'(q);
      end
      if (q > 64'd2147483647) q = 64'd2147483647;
      return longint'(q);
   endfunction

   // Q8.56 back to Q4.28, rounding toward minus infinity
   function automatic longint floor_q28(input longint v);
      if (v >= 0) return v >>> 28;
      return -longint'(($unsigned(-v) + 64'd268435455) >> 28);
   endfunction

   function automatic longint sat_s32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic rsp_type predict_pixel(input req_type p);
      longint unsigned w, h, r, mx, my, ar, ai, rr, ii;
      longint dx, dy, zr, zi, cr, ci;
      int unsigned n, lim, v;
      rsp_type o;
      w = (shadow_width == 0) ? 1 : (shadow_width > MAX_DIMENSION) ? MAX_DIMENSION
          : shadow_width;
      h = (shadow_height == 0) ? 1 : (shadow_height > MAX_DIMENSION) ? MAX_DIMENSION
          : shadow_height;
      r = (shadow_ratio == 0) ? 1 : shadow_ratio;
      lim = shadow_limit;
      dx = 2 * longint'(p.pixel_x) - longint'(w);
      dy = 2 * longint'(p.pixel_y) - longint'(h);
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      if (r >= 65536) begin
         zr = clamp_q28(dx < 0, (mx * r) << 13, w);
         zi = clamp_q28(dy < 0, my << 29, h);
      end else begin
         zr = clamp_q28(dx < 0, mx << 29, w);
         zi = clamp_q28(dy < 0, my << 45, h * r);
      end
      cr = longint'(signed'(shadow_c_real));
      ci = longint'(signed'(shadow_c_imag));
      n = 1;
      forever begin
         ar = (zr < 0) ? -zr : zr;
         ai = (zi < 0) ? -zi : zi;
         rr = ar * ar;
         ii = ai * ai;
         if (rr + ii >= (64'd4 << 56) || n > lim) break;
         // components below 2.0 here, so the products fit
         begin
            longint nr, ni;
            nr = floor_q28(longint'(rr) - longint'(ii)) + cr;
            ni = floor_q28(2 * (zr * zi)) + ci;
            zr = sat_s32(nr);
            zi = sat_s32(ni);
         end
         n++;
      end
      v = (n < lim) ? (255 * n) / lim : 0;
      o.escape_value = v[7:0];
      o.red   = (v == 0) ? 8'd0 : 8'd255;
      o.green = (v == 0) ? 8'd0 : 8'(255 - v);
      o.blue  = o.green;
      return o;
   endfunction

   // ---- configuration port: setup then access phase, then an idle phase ----
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);   // write lands here
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_C_REAL: shadow_c_real = value;
         REG_C_IMAG: shadow_c_imag = value;
         REG_LIMIT:  shadow_limit  = value[9:0];
         REG_WIDTH:  shadow_width  = value[12:0];
         REG_HEIGHT: shadow_height = value[12:0];
         REG_RATIO:  shadow_ratio  = value[23:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_all(input logic [31:0] cre, input logic [31:0] cim,
                          input logic [31:0] lim, input logic [31:0] w,
                          input logic [31:0] h, input logic [31:0] r);
      csr_write(REG_C_REAL, cre);
      csr_write(REG_C_IMAG, cim);
      csr_write(REG_LIMIT, lim);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_RATIO, r);
   endtask

   // ---- sender: random gaps, valid held until accepted ----
   task automatic send_pixel(input req_type p, input bit fixed, input rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      expected_pixels.push_back(fixed ? want : predict_pixel(p));
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---- receiver: random stall plus the long hold-off, and the checker ----
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected pixel result %h", rsp_payload);
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_payload.escape_value !== want.escape_value ||
                   rsp_payload.red !== want.red || rsp_payload.green !== want.green ||
                   rsp_payload.blue !== want.blue) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("pixel mismatch: expected v=%0d rgb=%0d,%0d,%0d %s",
                              want.escape_value, want.red, want.green, want.blue,
                              $sformatf("got v=%0d rgb=%0d,%0d,%0d",
                                        rsp_payload.escape_value, rsp_payload.red,
                                        rsp_payload.green, rsp_payload.blue));
               end
            end
         end
         rsp_stall <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // hold-off counted here so the sender keeps offering items meanwhile
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("julia_escape_time_pixel_unit_tb: errors");
         $finish;
      end
   end

   // directed rows at reset settings: c = 0, limit 255, 640x480, ratio 1.0
   typedef struct {
      logic [11:0] x;
      logic [11:0] y;
      bit          fixed;
      rsp_type     want;
   } pixel_row_type;

   localparam rsp_type FIRST_STEP_ESCAPE = '{8'd1, 8'd255, 8'd254, 8'd254};
   localparam rsp_type BLACK = '{8'd0, 8'd0, 8'd0, 8'd0};

   pixel_row_type directed_rows[12];

   initial begin
      req_type p;
      int ph, k;
      logic [31:0] we, he;
      shadow_c_real = 0; shadow_c_imag = 0; shadow_limit = 255;
      shadow_width = 640; shadow_height = 480; shadow_ratio = 65536;

      directed_rows[0]  = '{12'd0,    12'd0,    1, FIRST_STEP_ESCAPE};  // corner, |z|^2 = 8
      directed_rows[1]  = '{12'd320,  12'd240,  1, BLACK};  // centre, z stays at 0
      directed_rows[2]  = '{12'hFFF,  12'hFFF,  1, FIRST_STEP_ESCAPE};  // far outside, saturates
      directed_rows[3]  = '{12'hFFF,  12'd0,    1, FIRST_STEP_ESCAPE};
      directed_rows[4]  = '{12'd0,    12'hFFF,  1, FIRST_STEP_ESCAPE};
      directed_rows[5]  = '{12'd639,  12'd479,  1, FIRST_STEP_ESCAPE};  // last pixel
      directed_rows[6]  = '{12'd160,  12'd120,  0, BLACK};
      directed_rows[7]  = '{12'd480,  12'd100,  0, BLACK};
      directed_rows[8]  = '{12'd2048, 12'd1,    0, BLACK};
      directed_rows[9]  = '{12'd1,    12'd2048, 0, BLACK};
      directed_rows[10] = '{12'hAAA,  12'h555,  0, BLACK};
      directed_rows[11] = '{12'h555,  12'hAAA,  0, BLACK};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         p.pixel_x = directed_rows[i].x;
         p.pixel_y = directed_rows[i].y;
         send_pixel(p, directed_rows[i].fixed, directed_rows[i].want);
      end
      drain_pixels();

      // zero size, oversize height, zero ratio, zero limit: always black
      set_all(32'h0, 32'h0, 32'd0, 32'd0, 32'h1FFF, 32'd0);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      p = '{12'd0, 12'd0};       send_pixel(p, 1, BLACK);
      p = '{12'hFFF, 12'h800};   send_pixel(p, 1, BLACK);
      drain_pixels();
      // limit of one, widest ratio, extreme constants
      set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd4096, 32'd4096, 32'hFF_FFFF);
      p = '{12'd2048, 12'd2048}; send_pixel(p, 0, BLACK);
      p = '{12'd0, 12'hFFF};     send_pixel(p, 0, BLACK);
      drain_pixels();
      // tiny ratio divides the y span, full limit
      set_all(32'hF400_0000, 32'h0AE1_47AE, 32'd1023, 32'd64, 32'd48, 32'd1);
      p = '{12'd32, 12'd24};     send_pixel(p, 0, BLACK);
      p = '{12'd10, 12'd30};     send_pixel(p, 0, BLACK);
      drain_pixels();

      // random phases: the receiver idles more, then the sender idles more, then neither idles
      for (ph = 0; ph < 8; ph++) begin
         send_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 58 : 0;
         recv_idle_pct = (ph < 3) ? 58 : (ph < 6) ? 37 : 0;
         if (ph == 0)
            set_all(32'hF340_0000, 32'h0A00_0000, 32'd1023, 32'd4096, 32'd4096,
                    32'hFF_FFFF);
         else
            set_all(($urandom_range(0, 3) == 0) ? $urandom
                       : 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000 * 2 / 2
                         - 32'h0800_0000,
                    ($urandom_range(0, 3) == 0) ? $urandom
                       : 32'($urandom_range(0, 32'h1800_0000)) - 32'h0C00_0000,
                    (ph == 7) ? 32'd1 : 32'($urandom_range(1, 80)),
                    ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 8191))
                       : 32'($urandom_range(1, 4096)),
                    ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 8191))
                       : 32'($urandom_range(1, 4096)),
                    ($urandom_range(0, 5) == 0) ? 32'($urandom_range(0, 24'hFF_FFFF))
                       : 32'($urandom_range(16384, 262144)));
         we = (shadow_width == 0) ? 1 : (shadow_width > 4096) ? 4096 : shadow_width;
         he = (shadow_height == 0) ? 1 : (shadow_height > 4096) ? 4096 : shadow_height;
         if (ph == 1) hold_go <= 1'b1;  // block fills while the receiver holds off
         for (k = 0; k < 66; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               p.pixel_x = 12'($urandom);
               p.pixel_y = 12'($urandom);
            end else begin
               p.pixel_x = 12'($urandom_range(0, we - 1));
               p.pixel_y = 12'($urandom_range(0, he - 1));
            end
            send_pixel(p, 0, BLACK);
         end
         drain_pixels();
      end

      $display("checked %0d pixel results over eight random register settings,",
               pixels_checked);
      $display("directed corners and size, ratio and limit edge cases; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("julia_escape_time_pixel_unit_tb: clean");
      else
         $display("julia_escape_time_pixel_unit_tb: errors");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/jesc_pkg.sv
rtl/core/jesc_mul.sv
rtl/core/jesc_div.sv
rtl/core/julia_escape_time_pixel_unit.sv
tb/julia_escape_time_pixel_unit_tb.sv
